/* sv/value_noise_velocity_perturb_top_assert.svh */
// Assertion macros used by the top level of the noise perturbation RTL.
`ifndef VALUE_NOISE_VELOCITY_PERTURB_TOP_ASSERT_SVH
`define VALUE_NOISE_VELOCITY_PERTURB_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define VNVP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vnvp assertion failed");
// Next-cycle implication, disabled during reset.
`define VNVP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vnvp assertion failed");
`else
`define VNVP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define VNVP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* sv/vnvp_pkg.sv */
`timescale 1ns / 1ps
package vnvp_pkg;

   // Pipeline depth from request acceptance to the result register.
   localparam int NUM_STAGES = 11;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ENABLE       = 2'd0;
   localparam logic [1:0] CSR_FREQUENCY    = 2'd1;
   localparam logic [1:0] CSR_SCROLL_SPEED = 2'd2;
   localparam logic [1:0] CSR_STRENGTH     = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [23:0] RESET_Q8_16 = 24'd65536;

   // Fixed per-sample offsets, Q.16, on the scrolled axis.
   localparam logic [47:0] OFFSET_Y = 48'd897843;
   localparam logic [47:0] OFFSET_Z = 48'd478413;

   // Lattice hash constants.
   localparam logic [31:0] HASH_KX  = 32'd1031;
   localparam logic [31:0] HASH_KY  = 32'd2999;
   localparam logic [31:0] HASH_KZ  = 32'd4801;
   localparam logic [31:0] HASH_SQ  = 32'd15731;
   localparam logic [31:0] HASH_ADD = 32'd789221;
   localparam logic [31:0] HASH_FIN = 32'd1376312589;

   // Smoothstep constant 3.0 in Q.16.
   localparam logic [17:0] SMOOTH_THREE = 18'd196608;

endpackage

/* sv/vnvp_coord.sv */
`timescale 1ns / 1ps
module vnvp_coord
   import vnvp_pkg::*;
(
   input  logic               clock,
   input  logic [1:0]         stage_en,
   input  logic signed [31:0] pos_x,
   input  logic signed [31:0] pos_y,
   input  logic signed [31:0] pos_z,
   input  logic [31:0]        age,
   input  logic [15:0]        delta_time,
   input  logic [23:0]        frequency,
   input  logic [23:0]        scroll_speed,
   input  logic [23:0]        strength,
   output logic [31:0]        idx [3][3],
   output logic [15:0]        frac [3][3],
   output logic [39:0]        gain
);

   logic signed [56:0] pos_prod_ff [3];
   logic signed [56:0] pos_prod_in [3];
   logic [55:0]        age_prod_ff;
   logic [39:0]        gain_ff;
   logic [47:0]        base [3];
   logic [47:0]        scroll;
   logic [47:0]        coord [3][3];
   logic [31:0]        idx_ff [3][3];
   logic [15:0]        frac_ff [3][3];

   // Stage one: scale the position, the age and the gain.
   always_comb begin
      pos_prod_in[0] = pos_x * $signed({1'b0, frequency});
      pos_prod_in[1] = pos_y * $signed({1'b0, frequency});
      pos_prod_in[2] = pos_z * $signed({1'b0, frequency});
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pos_prod_ff <= pos_prod_in;
         age_prod_ff <= age * scroll_speed;
         gain_ff     <= strength * delta_time;
      end
   end

   // Stage two: build the three sample coordinates, low 48 bits only.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         base[a] = {{7{pos_prod_ff[a][56]}}, pos_prod_ff[a][56:16]};
      end
      scroll = {8'd0, age_prod_ff[55:16]};
      for (int s = 0; s < 3; s++) begin
         for (int a = 0; a < 3; a++) begin
            coord[s][a] = base[a];
         end
      end
      coord[0][0] = base[0] + scroll;
      coord[1][1] = base[1] + scroll + OFFSET_Y;
      coord[2][2] = base[2] + scroll + OFFSET_Z;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int s = 0; s < 3; s++) begin
            for (int a = 0; a < 3; a++) begin
               idx_ff[s][a]  <= coord[s][a][47:16];
               frac_ff[s][a] <= coord[s][a][15:0];
            end
         end
      end
   end

   assign idx  = idx_ff;
   assign frac = frac_ff;
   assign gain = gain_ff;

endmodule

/* sv/vnvp_hash.sv */
`timescale 1ns / 1ps
module vnvp_hash
   import vnvp_pkg::*;
(
   input  logic               clock,
   input  logic [3:0]         stage_en,
   input  logic [31:0]        x,
   input  logic [31:0]        y,
   input  logic [31:0]        z,
   output logic signed [15:0] value
);

   logic [31:0]        lin;
   logic [31:0]        h1_in;
   logic [31:0]        h1_ff;
   logic [31:0]        h1_d_ff;
   logic [31:0]        h1_dd_ff;
   logic [31:0]        sq_ff;
   logic [31:0]        poly_ff;
   logic [31:0]        fin;
   logic signed [15:0] value_ff;

   // Linear mix of the lattice point, then an arithmetic xor-shift.
   always_comb begin
      lin   = x * HASH_KX + y * HASH_KY + z * HASH_KZ;
      h1_in = lin ^ 32'($signed(lin) >>> 13);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         h1_ff <= h1_in;
      end
   end

   // Square of the mixed value.
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         sq_ff   <= h1_ff * h1_ff;
         h1_d_ff <= h1_ff;
      end
   end

   // Polynomial term.
   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         poly_ff  <= sq_ff * HASH_SQ + HASH_ADD;
         h1_dd_ff <= h1_d_ff;
      end
   end

   // Final product; bits 30..15 offset by one half give a Q0.15 value.
   assign fin = h1_dd_ff * poly_ff + HASH_FIN;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         value_ff <= {~fin[30], fin[29:15]};
      end
   end

   assign value = value_ff;

endmodule

/* sv/vnvp_smooth.sv */
`timescale 1ns / 1ps
module vnvp_smooth
   import vnvp_pkg::*;
(
   input  logic        clock,
   input  logic [1:0]  stage_en,
   input  logic [15:0] frac,
   output logic [15:0] weight
);

   logic [31:0] sq_ff;
   logic [17:0] tail_ff;
   logic [49:0] prod;
   logic [15:0] weight_ff;

   // First stage: f squared and 3 - 2f.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sq_ff   <= frac * frac;
         tail_ff <= SMOOTH_THREE - {1'b0, frac, 1'b0};
      end
   end

   // Second stage: the full cubic, scaled back to Q0.16.
   assign prod = sq_ff * tail_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         weight_ff <= prod[47:32];
      end
   end

   assign weight = weight_ff;

endmodule

/* sv/vnvp_lerp.sv */
`timescale 1ns / 1ps
module vnvp_lerp
   import vnvp_pkg::*;
(
   input  logic               clock,
   input  logic               stage_en,
   input  logic signed [15:0] a,
   input  logic signed [15:0] b,
   input  logic [15:0]        weight,
   output logic signed [15:0] result
);

   logic signed [16:0] diff;
   logic signed [33:0] prod;
   logic signed [17:0] step;
   logic signed [17:0] sum;
   logic signed [15:0] result_ff;

   // a + floor((b - a) * u / 2^16); the result stays between a and b.
   always_comb begin
      diff = 17'(b) - 17'(a);
      prod = diff * $signed({1'b0, weight});
      step = prod[33:16];
      sum  = 18'(a) + step;
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         result_ff <= sum[15:0];
      end
   end

   assign result = result_ff;

endmodule

/* sv/vnvp_apply.sv */
`timescale 1ns / 1ps
module vnvp_apply
   import vnvp_pkg::*;
(
   input  logic               clock,
   input  logic [1:0]         stage_en,
   input  logic               enable,
   input  logic signed [15:0] noise,
   input  logic [39:0]        gain,
   input  logic signed [31:0] vel_prod,
   input  logic signed [31:0] vel_out,
   output logic signed [31:0] new_vel
);

   logic signed [56:0] prod_ff;
   logic signed [31:0] vel_ff;
   logic signed [32:0] sum;
   logic signed [31:0] sat;
   logic signed [31:0] new_vel_ff;

   // Noise times strength times time step.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff <= noise * $signed({1'b0, gain});
         vel_ff  <= vel_prod;
      end
   end

   // Add to the velocity and clamp to the Q16.16 range.
   always_comb begin
      sum = 33'(vel_ff) + 33'($signed(prod_ff[56:31]));
      if (sum > 33'sd2147483647) begin
         sat = 32'sh7fffffff;
      end else if (sum < -33'sd2147483648) begin
         sat = 32'sh80000000;
      end else begin
         sat = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         new_vel_ff <= enable ? sat : vel_out;
      end
   end

   assign new_vel = new_vel_ff;

endmodule

/* sv/value_noise_velocity_perturb_top.sv */
`timescale 1ns / 1ps
// Velocity perturbation by hashed 3D value noise, one particle per request.
// Request channel: req_valid with position, age, velocity and time step;
// the block holds off with req_stall. Result channel: rsp_valid with the
// three new velocity components; the receiver holds off with rsp_stall.
// Configuration: csr_valid/csr_ready with csr_index and csr_data; writes
// are taken in any cycle but must only be issued while the block is idle.
// Throughput is one request per cycle: each of the 11 pipeline stages
// has its own valid bit, so a new request is taken every cycle that the
// result stage can drain.
// The longest stage is the hash's 32 by 32 bit product per lattice corner.
// When the receiver stalls, stages behind the held result keep moving until
// they fill up; req_stall rises only when every stage holds a request.
// Reset clears all valid bits and loads enable=1 and 1.0 into frequency,
// scroll speed and strength; no result is pending after reset.
module value_noise_velocity_perturb_top
   import vnvp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [31:0]        req_age,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic [15:0]        req_delta_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_new_vel_x,
   output logic signed [31:0] rsp_new_vel_y,
   output logic signed [31:0] rsp_new_vel_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_data
);

`include "value_noise_velocity_perturb_top_assert.svh"

   logic               enable_ff;
   logic [23:0]        frequency_ff;
   logic [23:0]        scroll_speed_ff;
   logic [23:0]        strength_ff;
   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] en;
   logic signed [31:0] vel_ff [1:NUM_STAGES-1][3];
   logic [39:0]        gain_ff [2:NUM_STAGES-2];
   logic [39:0]        gain1;
   logic [31:0]        idx [3][3];
   logic [15:0]        frac [3][3];
   logic [15:0]        weight [3][3];
   logic [15:0]        weight_ff [5:8][3][3];
   logic signed [15:0] corner [3][8];
   logic signed [15:0] lerp_x [3][4];
   logic signed [15:0] lerp_y [3][2];
   logic signed [15:0] noise [3];
   logic signed [31:0] new_vel [3];

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b1;
         frequency_ff    <= RESET_Q8_16;
         scroll_speed_ff <= RESET_Q8_16;
         strength_ff     <= RESET_Q8_16;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE:       enable_ff       <= csr_data[0];
            CSR_FREQUENCY:    frequency_ff    <= csr_data;
            CSR_SCROLL_SPEED: scroll_speed_ff <= csr_data;
            CSR_STRENGTH:     strength_ff     <= csr_data;
            default:          enable_ff       <= enable_ff;
         endcase
      end
   end

   // Stage advance: a stage loads when it is empty or its successor loads.
   always_comb begin
      en[NUM_STAGES] = !valid_ff[NUM_STAGES] || !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[1];
   assign rsp_valid = valid_ff[NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // Velocity and gain travel alongside the noise computation.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         vel_ff[1][0] <= req_vel_x;
         vel_ff[1][1] <= req_vel_y;
         vel_ff[1][2] <= req_vel_z;
      end
      for (int k = 2; k <= NUM_STAGES - 1; k++) begin
         if (en[k]) begin
            vel_ff[k] <= vel_ff[k-1];
         end
      end
      if (en[2]) begin
         gain_ff[2] <= gain1;
      end
      for (int k = 3; k <= NUM_STAGES - 2; k++) begin
         if (en[k]) begin
            gain_ff[k] <= gain_ff[k-1];
         end
      end
   end

   // Stages one and two: sample coordinates.
   vnvp_coord u_coord (
      .clock        (clock),
      .stage_en     (en[2:1]),
      .pos_x        (req_pos_x),
      .pos_y        (req_pos_y),
      .pos_z        (req_pos_z),
      .age          (req_age),
      .delta_time   (req_delta_time),
      .frequency    (frequency_ff),
      .scroll_speed (scroll_speed_ff),
      .strength     (strength_ff),
      .idx          (idx),
      .frac         (frac),
      .gain         (gain1)
   );

   // Stages three to six: corner hashes and smoothstep weights.
   for (genvar s = 0; s < 3; s++) begin : g_sample
      for (genvar c = 0; c < 8; c++) begin : g_corner
         vnvp_hash u_hash (
            .clock    (clock),
            .stage_en (en[6:3]),
            .x        (idx[s][0] + 32'(c % 2)),
            .y        (idx[s][1] + 32'((c / 2) % 2)),
            .z        (idx[s][2] + 32'(c / 4)),
            .value    (corner[s][c])
         );
      end
      for (genvar a = 0; a < 3; a++) begin : g_axis
         vnvp_smooth u_smooth (
            .clock    (clock),
            .stage_en (en[4:3]),
            .frac     (frac[s][a]),
            .weight   (weight[s][a])
         );
      end

      // Stage seven: blend along x.
      for (genvar m = 0; m < 4; m++) begin : g_lx
         vnvp_lerp u_lerp (
            .clock    (clock),
            .stage_en (en[7]),
            .a        (corner[s][2*m]),
            .b        (corner[s][2*m+1]),
            .weight   (weight_ff[6][s][0]),
            .result   (lerp_x[s][m])
         );
      end

      // Stage eight: blend along y.
      for (genvar m = 0; m < 2; m++) begin : g_ly
         vnvp_lerp u_lerp (
            .clock    (clock),
            .stage_en (en[8]),
            .a        (lerp_x[s][2*m]),
            .b        (lerp_x[s][2*m+1]),
            .weight   (weight_ff[7][s][1]),
            .result   (lerp_y[s][m])
         );
      end

      // Stage nine: blend along z.
      vnvp_lerp u_lerp_z (
         .clock    (clock),
         .stage_en (en[9]),
         .a        (lerp_y[s][0]),
         .b        (lerp_y[s][1]),
         .weight   (weight_ff[8][s][2]),
         .result   (noise[s])
      );

      // Stages ten and eleven: scale, add and clamp.
      vnvp_apply u_apply (
         .clock    (clock),
         .stage_en (en[11:10]),
         .enable   (enable_ff),
         .noise    (noise[s]),
         .gain     (gain_ff[NUM_STAGES-2]),
         .vel_prod (vel_ff[NUM_STAGES-2][s]),
         .vel_out  (vel_ff[NUM_STAGES-1][s]),
         .new_vel  (new_vel[s])
      );
   end

   // Smoothstep weights wait for their blend stage.
   always_ff @(posedge clock) begin
      if (en[5]) begin
         weight_ff[5] <= weight;
      end
      for (int k = 6; k <= 8; k++) begin
         if (en[k]) begin
            weight_ff[k] <= weight_ff[k-1];
         end
      end
   end

   assign rsp_new_vel_x = new_vel[0];
   assign rsp_new_vel_y = new_vel[1];
   assign rsp_new_vel_z = new_vel[2];

   // Requests are held off only when every stage is occupied and stalled.
   `VNVP_ASSERT_IMP(a_stall_full, clock, reset, req_stall, rsp_valid && rsp_stall && (&valid_ff))
   // A request moving into the result stage shows up as a result.
   `VNVP_ASSERT_NXT(a_result_loads, clock, reset, valid_ff[NUM_STAGES-1] && en[NUM_STAGES],
                    rsp_valid)
   // A blocked stage keeps its request.
   `VNVP_ASSERT_NXT(a_stage_holds, clock, reset, valid_ff[5] && !en[6], valid_ff[5])

endmodule
